// ===== rtl/matrix_multiply_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the matrix multiply unit
// Shared property forms; they compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_UNIT_DEFINES_SVH
`define MATRIX_MULTIPLY_UNIT_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define MMU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mmu assertion failed");

// next-cycle implication
`define MMU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mmu assertion failed");

`else

`define MMU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MMU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/mmu_pkg.sv =====
// ----------------------------------------------------------------------------
// mmu_pkg
// Widths, codes, shared types and helpers of the matrix multiply unit.
// ----------------------------------------------------------------------------
package mmu_pkg;

	localparam int IDX_W       = 3;   // row/column index width
	localparam int DATA_W      = 32;  // Q16.16 element width
	localparam int DIM_W       = 4;   // dimension register width
	localparam int CFG_IDX_W   = 2;   // register index width
	localparam int MAX_DIM_DEF = 8;

	// commands
	localparam logic [1:0] CMD_LOAD_A  = 2'd0;
	localparam logic [1:0] CMD_LOAD_B  = 2'd1;
	localparam logic [1:0] CMD_COMPUTE = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 2'd3;

	localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

	// rounding and saturation constants for Q32.32 -> Q16.16
	localparam logic [DATA_W-1:0] RND_HALF = 32'h0000_8000;
	localparam logic [DATA_W-1:0] SAT_MAX  = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] SAT_MIN  = 32'h8000_0000;

	// token passed down the cell chain: one A element of the current row
	typedef struct packed {
		logic                     vld;
		logic                     first;  // k == 0, restart accumulation
		logic                     fin;    // last k of the dot product
		logic [IDX_W-1:0]         k;
		logic signed [DATA_W-1:0] a;
	} cell_tok_t;

	typedef struct packed {
		logic [DIM_W-1:0] a_rows;
		logic [DIM_W-1:0] a_cols;
		logic [DIM_W-1:0] b_rows;
		logic [DIM_W-1:0] b_cols;
	} dims_t;

	// effective dimension minus one: 0 counts as 1, above maxd counts as maxd
	function automatic logic [IDX_W-1:0] eff_last(input logic [DIM_W-1:0] v,
	                                               input int unsigned maxd);
		logic [DIM_W-1:0] e;
		logic [DIM_W-1:0] d;
		if (v == '0)
			e = DIM_W'(1);
		else if (v > DIM_W'(maxd))
			e = DIM_W'(maxd);
		else
			e = v;
		d = e - DIM_W'(1);
		return d[IDX_W-1:0];
	endfunction

endpackage

// ===== rtl/matrix_multiply_unit.sv =====
// Load items may follow back to back.
// A compute item, per row of the result, feeds a_cols elements of A into the cell chain,
// waits for the far cell to finish, then drains b_cols results of that row (held by output stall).
// A misaligned compute gives a single error result.
// Reset is asynchronous, active low; dimension registers reset to 8, stores are not cleared.
// ----------------------------------------------------------------------------
// matrix_multiply_unit
// Signed Q16.16 matrix product A x B over a chain of column cells, one
// multiply-accumulate per cell per cycle while a row is fed, results in row-major order.
// ----------------------------------------------------------------------------
`include "matrix_multiply_unit_defines.svh"

module matrix_multiply_unit import mmu_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [DIM_W-1:0]         cfg_data,
	// input items
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               command,
	input  logic [IDX_W-1:0]         row_index,
	input  logic [IDX_W-1:0]         col_index,
	input  logic signed [DATA_W-1:0] element_value,
	// result items
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [IDX_W-1:0]         out_row,
	output logic [IDX_W-1:0]         out_col,
	output logic signed [DATA_W-1:0] product_value,
	output logic                     last_element,
	output logic                     misaligned
);

	dims_t                          dims_q;
	logic                           in_acc, busy, b_load;
	cell_tok_t                      tok_chain [MAX_DIM+1];
	logic [MAX_DIM-1:0][DATA_W-1:0] res_vec;
	logic [MAX_DIM-1:0]             done_vec;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = busy;
	assign b_load   = in_acc && (command == CMD_LOAD_B) &&
	                  ({1'b0, row_index} < DIM_W'(MAX_DIM));

	// dimension registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= '{a_rows: DIM_RESET, a_cols: DIM_RESET,
			            b_rows: DIM_RESET, b_cols: DIM_RESET};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_A_ROWS: dims_q.a_rows <= cfg_data;
				REG_A_COLS: dims_q.a_cols <= cfg_data;
				REG_B_ROWS: dims_q.b_rows <= cfg_data;
				REG_B_COLS: dims_q.b_cols <= cfg_data;
				default: dims_q <= dims_q;
			endcase
		end
	end

	mmu_ctrl #(
		.MAX_DIM (MAX_DIM)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_acc        (in_acc),
		.command       (command),
		.row_index     (row_index),
		.col_index     (col_index),
		.element_value (element_value),
		.dims          (dims_q),
		.res_vec       (res_vec),
		.done_last     (done_vec[MAX_DIM-1]),
		.out_stall     (out_stall),
		.busy          (busy),
		.tok           (tok_chain[0]),
		.out_valid     (out_valid),
		.out_row       (out_row),
		.out_col       (out_col),
		.product_value (product_value),
		.last_element  (last_element),
		.misaligned    (misaligned)
	);

	// chain of column cells; the A element moves one cell per cycle
	for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
		mmu_cell #(
			.MAX_DIM (MAX_DIM)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok_chain[j]),
			.b_we    (b_load && (col_index == IDX_W'(j))),
			.b_addr  (row_index),
			.b_data  (element_value),
			.tok_out (tok_chain[j+1]),
			.result  (res_vec[j]),
			.done    (done_vec[j])
		);
	end

	// cells finish staggered, never two at once
	`MMU_ASSERT_IMP(a_done_stagger, clk, arst_n, 1'b1, $onehot0(done_vec))
	// a token leaving the chain means a compute is still in progress
	`MMU_ASSERT_IMP(a_tail_busy, clk, arst_n, tok_chain[MAX_DIM].vld, in_stall)
	// a compute transfer blocks further input on the next cycle
	`MMU_ASSERT_NXT(a_compute_busy, clk, arst_n, in_acc && (command == CMD_COMPUTE), in_stall)
	// the error result is always the final one
	`MMU_ASSERT_IMP(a_err_last, clk, arst_n, out_valid && misaligned, last_element)

endmodule

// ===== rtl/mmu_cell.sv =====
// ----------------------------------------------------------------------------
// mmu_cell
// One column cell: holds column j of B, multiplies the passing A element by
// B[k][j], accumulates exactly, then rounds and saturates to Q16.16.
// ----------------------------------------------------------------------------
module mmu_cell import mmu_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_tok_t                tok_in,
	input  logic                     b_we,
	input  logic [IDX_W-1:0]         b_addr,
	input  logic [DATA_W-1:0]        b_data,
	output cell_tok_t                tok_out,
	output logic [DATA_W-1:0]        result,
	output logic                     done
);

	localparam int KW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int ACC_W = 2 * DATA_W + $clog2(MAX_DIM) + 1;

	logic [DATA_W-1:0]        bank_q [MAX_DIM];
	cell_tok_t                tok_q;

	logic                     vld_s1, first_s1, fin_s1;
	logic signed [DATA_W-1:0] a_s1, b_s1;
	logic                     vld_s2, first_s2, fin_s2;
	logic signed [2*DATA_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     fin_s3;
	logic [DATA_W-1:0]        res_q;
	logic                     done_q;

	logic [ACC_W-1:0]         rnd;
	logic [ACC_W-DATA_W-16:0] rnd_hi;
	logic [DATA_W-1:0]        sat;

	// column store of B, one word per row
	always_ff @(posedge clk) begin
		if (b_we)
			bank_q[b_addr[KW-1:0]] <= b_data;
	end

	// read B[k][j] alongside the passing A element
	always_ff @(posedge clk) begin
		a_s1 <= tok_in.a;
		b_s1 <= bank_q[tok_in.k[KW-1:0]];
		first_s1 <= tok_in.first;
		fin_s1 <= tok_in.fin;
		prod_s2 <= a_s1 * b_s1;
		first_s2 <= first_s1;
		fin_s2 <= fin_s1;
		if (fin_s3)
			res_q <= sat;
	end

	// control bits, token hand-off and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			fin_s3 <= 1'b0;
			done_q <= 1'b0;
			acc_q <= '0;
		end else begin
			tok_q <= tok_in;
			vld_s1 <= tok_in.vld;
			vld_s2 <= vld_s1;
			fin_s3 <= vld_s2 && fin_s2;
			done_q <= fin_s3;
			if (vld_s2) begin
				if (first_s2)
					acc_q <= ACC_W'(prod_s2);
				else
					acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	// round to nearest (ties up), then clamp to 32 bits
	always_comb begin
		rnd = acc_q + ACC_W'(RND_HALF);
		rnd_hi = rnd[ACC_W-1:DATA_W+15];
		if ((&rnd_hi) || !(|rnd_hi))
			sat = rnd[DATA_W+15:16];
		else if (rnd[ACC_W-1])
			sat = SAT_MIN;
		else
			sat = SAT_MAX;
	end

	assign tok_out = tok_q;
	assign result  = res_q;
	assign done    = done_q;

endmodule

// ===== rtl/mmu_ctrl.sv =====
// ----------------------------------------------------------------------------
// mmu_ctrl
// Command sequencer: holds the A store, streams row i of A into the cell
// chain, then drains the row's results in column order to the output register.
// ----------------------------------------------------------------------------
module mmu_ctrl import mmu_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_acc,
	input  logic [1:0]                      command,
	input  logic [IDX_W-1:0]                row_index,
	input  logic [IDX_W-1:0]                col_index,
	input  logic [DATA_W-1:0]               element_value,
	input  dims_t                           dims,
	input  logic [MAX_DIM-1:0][DATA_W-1:0]  res_vec,
	input  logic                            done_last,
	input  logic                            out_stall,
	output logic                            busy,
	output cell_tok_t                       tok,
	output logic                            out_valid,
	output logic [IDX_W-1:0]                out_row,
	output logic [IDX_W-1:0]                out_col,
	output logic [DATA_W-1:0]               product_value,
	output logic                            last_element,
	output logic                            misaligned
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int KW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	typedef enum logic [2:0] {ST_IDLE, ST_FEED, ST_WAIT, ST_OUT, ST_ERR} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   i_q, j_q, k_q;
	logic [DATA_W-1:0]  a_mem [DEPTH];
	logic [DATA_W-1:0]  a_rd_s1;
	logic               tok_vld_s1, tok_first_s1, tok_fin_s1;
	logic [IDX_W-1:0]   tok_k_s1;
	logic               out_valid_q, out_last_q, out_mis_q;
	logic [IDX_W-1:0]   out_row_q, out_col_q;
	logic [DATA_W-1:0]  out_value_q;

	logic [IDX_W-1:0]   nr_last, nm_last, nk_last, nc_last;
	logic               in_range, a_we, out_free;
	logic [AW-1:0]      wr_addr, rd_addr;

	assign nr_last = eff_last(dims.a_rows, MAX_DIM);
	assign nm_last = eff_last(dims.a_cols, MAX_DIM);
	assign nk_last = eff_last(dims.b_rows, MAX_DIM);
	assign nc_last = eff_last(dims.b_cols, MAX_DIM);

	assign in_range = ({1'b0, row_index} < DIM_W'(MAX_DIM)) &&
	                  ({1'b0, col_index} < DIM_W'(MAX_DIM));
	assign a_we     = in_acc && (command == CMD_LOAD_A) && in_range;
	assign wr_addr  = AW'(32'(row_index) * MAX_DIM + 32'(col_index));
	assign rd_addr  = AW'(32'(i_q) * MAX_DIM + 32'(k_q));
	assign out_free = !out_valid_q || !out_stall;

	// A store, row-major
	always_ff @(posedge clk) begin
		if (a_we)
			a_mem[wr_addr] <= element_value;
		a_rd_s1 <= a_mem[rd_addr];
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			tok_vld_s1 <= 1'b0;
			tok_first_s1 <= 1'b0;
			tok_fin_s1 <= 1'b0;
			tok_k_s1 <= '0;
			out_valid_q <= 1'b0;
			out_row_q <= '0;
			out_col_q <= '0;
			out_value_q <= '0;
			out_last_q <= 1'b0;
			out_mis_q <= 1'b0;
		end else begin
			tok_vld_s1 <= 1'b0;
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (command == CMD_COMPUTE)) begin
						if (nm_last != nk_last) begin
							state_q <= ST_ERR;
						end else begin
							i_q <= '0;
							k_q <= '0;
							state_q <= ST_FEED;
						end
					end
				end
				// one A element of row i per cycle
				ST_FEED: begin
					tok_vld_s1 <= 1'b1;
					tok_first_s1 <= (k_q == '0);
					tok_fin_s1 <= (k_q == nm_last);
					tok_k_s1 <= k_q;
					if (k_q == nm_last) begin
						k_q <= '0;
						state_q <= ST_WAIT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				// the far cell finishes last
				ST_WAIT: begin
					if (done_last) begin
						j_q <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_row_q <= i_q;
						out_col_q <= j_q;
						out_value_q <= res_vec[j_q[KW-1:0]];
						out_last_q <= (i_q == nr_last) && (j_q == nc_last);
						out_mis_q <= 1'b0;
						if (j_q == nc_last) begin
							if (i_q == nr_last) begin
								state_q <= ST_IDLE;
							end else begin
								i_q <= i_q + 1'b1;
								state_q <= ST_FEED;
							end
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				ST_ERR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_row_q <= '0;
						out_col_q <= '0;
						out_value_q <= '0;
						out_last_q <= 1'b1;
						out_mis_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign tok           = '{vld: tok_vld_s1, first: tok_first_s1, fin: tok_fin_s1,
	                         k: tok_k_s1, a: a_rd_s1};
	assign out_valid     = out_valid_q;
	assign out_row       = out_row_q;
	assign out_col       = out_col_q;
	assign product_value = out_value_q;
	assign last_element  = out_last_q;
	assign misaligned    = out_mis_q;

endmodule
